// ===== hw/rtl/ssoca_pkg.sv =====
package ssoca_pkg;

  localparam logic [31:0] FULL_SCALE_CURRENT = 32'd4000000000;
  localparam int          MICROSTEP_EXP      = 8;

  localparam int PERMILLE_W   = 10;
  localparam int SMOOTH_SHIFT = 13;
  localparam int SLOPE_W      = 32 - SMOOTH_SHIFT;
  localparam int MAG_W        = 15;
  localparam int OVER_W       = 13;
  localparam int REM_W        = SMOOTH_SHIFT;

  localparam logic [PERMILLE_W-1:0] PERMILLE_MAX       = 10'd1000;
  localparam logic [PERMILLE_W-1:0] MAX_CURRENT_RESET  = 10'd1000;
  localparam logic [PERMILLE_W-1:0] HOLD_CURRENT_RESET = 10'd150;

  localparam logic [31:0] CURRENT_PER_PERMILLE = FULL_SCALE_CURRENT / 32'd1000;

  localparam logic signed [31:0] QUARTER_TURN     = 32'sd16384;
  localparam logic signed [31:0] NEG_QUARTER_TURN = -32'sd16384;
  localparam logic [16:0]        EIGHTH_TURN      = 17'd8192;
  localparam logic [16:0]        MICROSTEP        = 17'd1 << (16 - MICROSTEP_EXP);
  localparam logic [31:0]        LEAD_ANGLE       = 32'h4000_0000;

  typedef enum logic [0:0] {
    REG_MAX_CURRENT  = 1'b0,
    REG_HOLD_CURRENT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]        cmax;
    logic [31:0]        chold;
    logic [SLOPE_W-1:0] slope;
  } limits_t;

  typedef struct packed {
    logic               update_valid;
    logic signed [31:0] position_error;
    logic [15:0]        actual_position;
    logic [15:0]        position_forecast;
    logic [31:0]        start_offset;
    logic [15:0]        target_position;
    logic               stepping;
  } update_t;

  typedef struct packed {
    logic [31:0] drive_angle;
    logic [31:0] drive_current;
  } drive_t;

  function automatic logic [31:0] scale_permille(input logic [PERMILLE_W-1:0] p);
    logic [PERMILLE_W-1:0]   sat;
    logic [PERMILLE_W+31:0]  prod;
    sat  = (p > PERMILLE_MAX) ? PERMILLE_MAX : p;
    prod = {32'd0, sat} * {{PERMILLE_W{1'b0}}, CURRENT_PER_PERMILLE};
    return prod[31:0];
  endfunction

  function automatic limits_t derive_limits(input logic [31:0] smax,
                                            input logic [31:0] shold);
    limits_t     l;
    logic [31:0] diff;
    l.cmax  = (smax < shold) ? shold : smax;
    l.chold = shold;
    diff    = l.cmax - shold;
    l.slope = diff[31:SMOOTH_SHIFT];
    return l;
  endfunction

endpackage

// ===== hw/rtl/ssoca_cfg.sv =====
module ssoca_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [ssoca_pkg::PERMILLE_W-1:0]    cfg_data,
  output ssoca_pkg::limits_t                  limits
);
  import ssoca_pkg::*;

  logic [31:0] max_scaled;
  logic [31:0] hold_scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_scaled  <= scale_permille(MAX_CURRENT_RESET);
      hold_scaled <= scale_permille(HOLD_CURRENT_RESET);
      limits      <= derive_limits(scale_permille(MAX_CURRENT_RESET),
                                   scale_permille(HOLD_CURRENT_RESET));
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAX_CURRENT:  max_scaled  <= scale_permille(cfg_data);
          REG_HOLD_CURRENT: hold_scaled <= scale_permille(cfg_data);
          default: ;
        endcase
      end
      limits <= derive_limits(max_scaled, hold_scaled);
    end
  end

endmodule

// ===== hw/rtl/ssoca_core.sv =====
module ssoca_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  ssoca_pkg::update_t  upd,
  input  ssoca_pkg::limits_t  limits,
  output ssoca_pkg::drive_t   result
);
  import ssoca_pkg::*;

  logic [31:0]      present_current;
  logic [REM_W-1:0] smoothing_remainder;

  logic               lead;
  logic [15:0]        fpos;
  logic [31:0]        base_angle;
  logic [31:0]        err_abs;
  logic [MAG_W-1:0]   mag;
  logic [16:0]        mag_ext;
  logic [16:0]        over_full;
  logic [OVER_W-1:0]  over;
  logic [31:0]        ramp;
  logic [31:0]        cur;
  logic               rise;
  logic signed [32:0] gap;
  logic signed [32:0] quarter;
  logic signed [33:0] acc;
  logic signed [33:0] whole;
  logic signed [33:0] eased;
  logic [31:0]        eased_clamped;
  logic [31:0]        present_next;
  logic [REM_W-1:0]   remainder_next;

  always_comb begin
    lead = (upd.position_error > QUARTER_TURN) || (upd.position_error < NEG_QUARTER_TURN);
    fpos = upd.actual_position + upd.position_forecast;
    base_angle = {(lead ? fpos : upd.target_position), 16'h0000} + upd.start_offset;

    err_abs   = upd.position_error[31] ? (32'd0 - upd.position_error) : upd.position_error;
    mag       = err_abs[MAG_W-1:0];
    mag_ext   = {{(17-MAG_W){1'b0}}, mag};
    over_full = mag_ext - MICROSTEP;
    over      = over_full[OVER_W-1:0];
    ramp      = limits.chold + (32'(limits.slope) * 32'(over));

    if (upd.stepping || mag_ext > EIGHTH_TURN) begin
      cur = limits.cmax;
    end else if (mag_ext <= MICROSTEP) begin
      cur = limits.chold;
    end else begin
      cur = ramp;
    end

    // falling current: quarter of the gap into the accumulator, floor rounding
    rise    = cur > present_current;
    gap     = $signed({1'b0, cur}) - $signed({1'b0, present_current});
    quarter = gap >>> 2;
    acc     = $signed({{(34-REM_W){1'b0}}, smoothing_remainder}) + {quarter[32], quarter};
    whole   = acc >>> SMOOTH_SHIFT;
    eased   = $signed({2'b00, present_current}) + whole;
    eased_clamped = eased[33] ? 32'd0 : eased[31:0];

    if (lead) begin
      present_next   = limits.cmax;
      remainder_next = smoothing_remainder;
      result.drive_angle = upd.position_error[31] ? (base_angle - LEAD_ANGLE)
                                                  : (base_angle + LEAD_ANGLE);
    end else if (rise) begin
      present_next   = cur;
      remainder_next = '0;
      result.drive_angle = base_angle;
    end else begin
      present_next   = eased_clamped;
      remainder_next = acc[REM_W-1:0];
      result.drive_angle = base_angle;
    end
    result.drive_current = present_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_current     <= '0;
      smoothing_remainder <= '0;
    end else if (fire) begin
      present_current     <= present_next;
      smoothing_remainder <= remainder_next;
    end
  end

endmodule

// ===== hw/rtl/stepper_semi_open_current_and_angle.sv =====
// Semi-open stepper drive: for each update transfer the block returns one
// electrical drive angle and coil current (none when update_valid is 0).
// An update is registered on entry, computed in one pass and held in an
// output register, so one transfer per cycle is sustained unless drive_ready
// stalls the output; the only loop is the present current and easing
// accumulator state, updated in that single pass. Current limits written on
// the configuration port take effect via the scaled, then limits registers.
module stepper_semi_open_current_and_angle (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_index,
  input  logic [ssoca_pkg::PERMILLE_W-1:0] cfg_data,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  logic                             update_valid,
  input  logic signed [31:0]               position_error,
  input  logic [15:0]                      actual_position,
  input  logic [15:0]                      position_forecast,
  input  logic [31:0]                      start_offset,
  input  logic [15:0]                      target_position,
  input  logic                             stepping,
  output logic                             drive_valid,
  input  logic                             drive_ready,
  output logic [31:0]                      drive_angle,
  output logic [31:0]                      drive_current
);
  import ssoca_pkg::*;

  limits_t limits;
  update_t upd;
  drive_t  result;
  logic    upd_valid;
  logic    upd_done;
  logic    fire;

  assign upd_done  = upd_valid && (!upd.update_valid || !drive_valid || drive_ready);
  assign fire      = upd_done && upd.update_valid;
  assign cmd_ready = !rst && (!upd_valid || upd_done);

  ssoca_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  ssoca_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .upd    (upd),
    .limits (limits),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid <= 1'b0;
    end else if (cmd_ready) begin
      upd_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      upd.update_valid      <= update_valid;
      upd.position_error    <= position_error;
      upd.actual_position   <= actual_position;
      upd.position_forecast <= position_forecast;
      upd.start_offset      <= start_offset;
      upd.target_position   <= target_position;
      upd.stepping          <= stepping;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (fire) begin
      drive_valid <= 1'b1;
    end else if (drive_ready) begin
      drive_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      drive_angle   <= result.drive_angle;
      drive_current <= result.drive_current;
    end
  end

endmodule
